// ----- hw/rtl/b64sc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream codec package
// Shared types, constants and alphabet conversion functions.
// ----------------------------------------------------------------------------
package b64sc_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef struct packed {
        logic [1:0]      last_idx;
        logic [3:0][7:0] chars;
        logic            data_valid;
        logic            stream_last;
        logic            err;
        logic            end_err;
    } t_packet;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
        logic [7:0] c;
        c = 8'h00;
        if (s < 6'd26) begin
            c = 8'h41 + {2'b00, s};
        end else if (s < 6'd52) begin
            c = 8'h61 + {2'b00, 6'(s - 6'd26)};
        end else if (s < 6'd62) begin
            c = 8'h30 + {2'b00, 6'(s - 6'd52)};
        end else if (s == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // Returns {ok, sextet}; characters outside the alphabet give zero.
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c inside {[8'h61:8'h7A]}) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/b64sc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream codec front end
// Holds the mode and stream state, converts one accepted byte per cycle
// into a packet of up to four results.
// ----------------------------------------------------------------------------
module b64sc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_write,
    input  logic               i_cfg_mode,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_stream_last,
    output logic               o_pkt_valid,
    output b64sc_pkg::t_packet o_pkt
);

    logic       r_mode;
    logic [1:0] r_pos;
    logic [5:0] r_carry;
    logic       r_pad;
    logic       r_err;

    logic [1:0] n_pos;
    logic [5:0] n_carry;
    logic       n_pad;
    logic       n_err;

    logic [2:0] w_cnt;
    logic [6:0] w_dec;
    logic [5:0] w_v;

    always_comb begin
        n_pos   = r_pos;
        n_carry = r_carry;
        n_pad   = r_pad;
        n_err   = r_err;
        w_cnt   = 3'd0;
        w_dec   = b64sc_pkg::char_to_sextet(i_data_byte);
        w_v     = w_dec[5:0];
        o_pkt   = '0;
        o_pkt.data_valid  = 1'b1;
        o_pkt.stream_last = i_stream_last;
        if (r_mode == b64sc_pkg::MODE_ENCODE) begin
            case (r_pos)
                2'd1: begin
                    o_pkt.chars[0] = b64sc_pkg::sextet_to_char(
                        r_carry | {2'b00, i_data_byte[7:4]});
                    n_carry = {i_data_byte[3:0], 2'b00};
                    n_pos   = 2'd2;
                    w_cnt   = 3'd1;
                end
                2'd2: begin
                    o_pkt.chars[0] = b64sc_pkg::sextet_to_char(
                        r_carry | {4'b0000, i_data_byte[7:6]});
                    o_pkt.chars[1] = b64sc_pkg::sextet_to_char(i_data_byte[5:0]);
                    n_carry = 6'd0;
                    n_pos   = 2'd0;
                    w_cnt   = 3'd2;
                end
                default: begin
                    o_pkt.chars[0] = b64sc_pkg::sextet_to_char(i_data_byte[7:2]);
                    n_carry = {i_data_byte[1:0], 4'b0000};
                    n_pos   = 2'd1;
                    w_cnt   = 3'd1;
                end
            endcase
            if (i_stream_last && n_pos == 2'd1) begin
                o_pkt.chars[1] = b64sc_pkg::sextet_to_char(n_carry);
                o_pkt.chars[2] = b64sc_pkg::PAD_CHAR;
                o_pkt.chars[3] = b64sc_pkg::PAD_CHAR;
                w_cnt = 3'd4;
            end else if (i_stream_last && n_pos == 2'd2) begin
                o_pkt.chars[1] = b64sc_pkg::sextet_to_char(n_carry);
                o_pkt.chars[2] = b64sc_pkg::PAD_CHAR;
                w_cnt = 3'd3;
            end
            o_pkt.end_err = r_err;
        end else begin
            if (!r_pad) begin
                if (i_data_byte == b64sc_pkg::PAD_CHAR && r_pos[1]) begin
                    n_pad = 1'b1;
                end else begin
                    n_err = r_err | ~w_dec[6];
                    case (r_pos)
                        2'd0: begin
                            n_carry = w_v;
                        end
                        2'd1: begin
                            o_pkt.chars[0] = {r_carry, w_v[5:4]};
                            n_carry = {2'b00, w_v[3:0]};
                            w_cnt   = 3'd1;
                        end
                        2'd2: begin
                            o_pkt.chars[0] = {r_carry[3:0], w_v[5:2]};
                            n_carry = {4'b0000, w_v[1:0]};
                            w_cnt   = 3'd1;
                        end
                        default: begin
                            o_pkt.chars[0] = {r_carry[1:0], w_v};
                            n_carry = 6'd0;
                            w_cnt   = 3'd1;
                        end
                    endcase
                end
            end
            n_pos = 2'(r_pos + 2'd1);
            o_pkt.end_err = n_err | (n_pos != 2'd0);
            if (i_stream_last && w_cnt == 3'd0) begin
                o_pkt.data_valid = 1'b0;
                w_cnt = 3'd1;
            end
        end
        o_pkt.err      = n_err;
        o_pkt.last_idx = 2'(w_cnt - 3'd1);
        o_pkt_valid    = i_accept && (w_cnt != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= b64sc_pkg::MODE_ENCODE;
            r_pos   <= 2'd0;
            r_carry <= 6'd0;
            r_pad   <= 1'b0;
            r_err   <= 1'b0;
        end else if (i_cfg_write) begin
            r_mode  <= i_cfg_mode;
            r_pos   <= 2'd0;
            r_carry <= 6'd0;
            r_pad   <= 1'b0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            if (i_stream_last) begin
                r_pos   <= 2'd0;
                r_carry <= 6'd0;
                r_pad   <= 1'b0;
                r_err   <= 1'b0;
            end else begin
                r_pos   <= n_pos;
                r_carry <= n_carry;
                r_pad   <= n_pad;
                r_err   <= n_err;
            end
        end
    end

endmodule

// ----- hw/rtl/b64sc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream codec packet queue
// Short first-in first-out queue of packets between front and back end.
// ----------------------------------------------------------------------------
module b64sc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  b64sc_pkg::t_packet i_pkt,
    input  logic               i_rd,
    output b64sc_pkg::t_packet o_pkt,
    output logic               o_full,
    output logic               o_empty
);

    b64sc_pkg::t_packet r_mem [b64sc_pkg::QDEPTH];

    logic [b64sc_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [b64sc_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [b64sc_pkg::QCNT_W-1:0] r_count;

    logic w_wr;
    logic w_rd;

    assign o_full  = (r_count == b64sc_pkg::QCNT_W'(b64sc_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_pkt   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + b64sc_pkg::QPTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + b64sc_pkg::QPTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + b64sc_pkg::QCNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - b64sc_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/b64sc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream codec back end
// Unpacks queued packets into single results and holds the output register.
// ----------------------------------------------------------------------------
module b64sc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  b64sc_pkg::t_packet i_pkt,
    output logic               o_q_rd,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [7:0]         o_out_byte,
    output logic               o_data_valid,
    output logic               o_run_last,
    output logic               o_stream_end,
    output logic               o_format_error
);

    logic       r_valid;
    logic [1:0] r_idx;
    logic [7:0] r_byte;
    logic       r_dv;
    logic       r_run_last;
    logic       r_end;
    logic       r_ferr;

    logic w_load;
    logic w_final;

    assign w_load  = !i_q_empty && (!r_valid || i_pop);
    assign w_final = (r_idx == i_pkt.last_idx);
    assign o_q_rd  = w_load && w_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_final ? 2'd0 : 2'(r_idx + 2'd1);
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte     <= i_pkt.data_valid ? i_pkt.chars[r_idx] : 8'h00;
            r_dv       <= i_pkt.data_valid;
            r_run_last <= w_final;
            r_end      <= w_final && i_pkt.stream_last;
            r_ferr     <= (w_final && i_pkt.stream_last) ? i_pkt.end_err : i_pkt.err;
        end
    end

    assign o_empty        = !r_valid;
    assign o_out_byte     = r_byte;
    assign o_data_valid   = r_dv;
    assign o_run_last     = r_run_last;
    assign o_stream_end   = r_end;
    assign o_format_error = r_ferr;

endmodule

// ----- hw/rtl/base64_stream_codec_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream codec top level
// Streaming Base64 encoder and decoder with the standard alphabet.
//
//   Channel   Direction  Handshake            Payload
//   input     in         push / full          i_data_byte, i_stream_last
//   result    out        empty / pop          o_out_byte, o_data_valid,
//                                             o_run_last, o_stream_end,
//                                             o_format_error
//   config    in         valid / ready        i_cfg_mode
//
// One input byte can be taken in every cycle while the packet queue has room.
// Each result leaves through the output register at one per cycle while pop
// is held, so an encode item that ends the stream gives up to four results.
// A result passes through the packet queue and then the output register after
// its item is taken. Reset is synchronous and clears mode and stream state;
// stalls on the result side back up through the four-entry queue to full.
// ----------------------------------------------------------------------------
module base64_stream_codec_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_stream_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_data_valid,
    output logic       o_run_last,
    output logic       o_stream_end,
    output logic       o_format_error,
    input  logic       valid,
    output logic       ready,
    input  logic       i_cfg_mode
);

    logic               w_accept;
    logic               w_pkt_valid;
    b64sc_pkg::t_packet w_pkt_in;
    b64sc_pkg::t_packet w_pkt_out;
    logic               w_q_full;
    logic               w_q_empty;
    logic               w_q_rd;

    assign ready    = 1'b1;
    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    b64sc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_write   (valid && ready),
        .i_cfg_mode    (i_cfg_mode),
        .i_accept      (w_accept),
        .i_data_byte   (i_data_byte),
        .i_stream_last (i_stream_last),
        .o_pkt_valid   (w_pkt_valid),
        .o_pkt         (w_pkt_in)
    );

    b64sc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_pkt_valid),
        .i_pkt   (w_pkt_in),
        .i_rd    (w_q_rd),
        .o_pkt   (w_pkt_out),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    b64sc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (w_q_empty),
        .i_pkt          (w_pkt_out),
        .o_q_rd         (w_q_rd),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_byte     (o_out_byte),
        .o_data_valid   (o_data_valid),
        .o_run_last     (o_run_last),
        .o_stream_end   (o_stream_end),
        .o_format_error (o_format_error)
    );

    a_end_is_run_last : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_stream_end) |-> o_run_last
    ) else $error("Stream end transfer without run_last");

    a_status_only_final : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_data_valid) |-> (o_run_last && o_stream_end && o_out_byte == 8'h00)
    ) else $error("Status-only transfer that does not end the stream");

    a_back_moves : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!w_q_empty && empty) |=> !empty
    ) else $error("Output register stayed empty while packets were queued");

endmodule
